// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the transcoder RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/u8cp_pkg.sv =====
// Types, constants and the CP850 reverse lookup for the UTF-8 to CP850 transcoder.
`default_nettype none
package u8cp_pkg;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TWO,
    PH_THREE_A,
    PH_THREE_B
  } phase_e;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       substituted;
    logic       run_last;
    logic       string_done;
  } result_t;

  // Results produced by one input transfer
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Outcome of the reverse table search
  typedef struct packed {
    logic       hit;
    logic [6:0] idx;
  } lookup_t;

  localparam logic [7:0] QMARK      = 8'h3F;
  localparam logic [7:0] ASCII_TOP  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;

  // Unicode codepoints of CP850 bytes 0x80..0xFF
  localparam logic [15:0] UCS_TABLE [0:127] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00F8, 16'h00A3, 16'h00D8, 16'h00D7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h00AE, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h00C1, 16'h00C2, 16'h00C0,
    16'h00A9, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h00A2, 16'h00A5, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h00E3, 16'h00C3,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h00A4,
    16'h00F0, 16'h00D0, 16'h00CA, 16'h00CB, 16'h00C8, 16'h0131, 16'h00CD, 16'h00CE,
    16'h00CF, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h00A6, 16'h00CC, 16'h2580,
    16'h00D3, 16'h00DF, 16'h00D4, 16'h00D2, 16'h00F5, 16'h00D5, 16'h00B5, 16'h00FE,
    16'h00DE, 16'h00DA, 16'h00DB, 16'h00D9, 16'h00FD, 16'h00DD, 16'h00AF, 16'h00B4,
    16'h00AD, 16'h00B1, 16'h2017, 16'h00BE, 16'h00B6, 16'h00A7, 16'h00F7, 16'h00B8,
    16'h00B0, 16'h00A8, 16'h00B7, 16'h00B9, 16'h00B3, 16'h00B2, 16'h25A0, 16'h00A0
  };

  // Parallel compare against all entries; the highest matching index wins
  function automatic lookup_t ucs_lookup(input logic [15:0] cp);
    lookup_t res;
    res = '0;
    for (int i = 0; i < 128; i++) begin
      if (UCS_TABLE[i] == cp) begin
        res.hit = 1'b1;
        res.idx = 7'(i);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/u8cp_outq.sv =====
// Three-entry result queue that absorbs up to two results per input transfer.
`default_nettype none
`include "assert_macros.svh"
module u8cp_outq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire u8cp_pkg::push_t  push_i,
  output logic                  room_o,
  output u8cp_pkg::result_t     head_o,
  output logic                  valid_o,
  input  wire logic             ready_i
);

  logic [1:0]        count_q, count_d;
  u8cp_pkg::result_t q_q [3];
  u8cp_pkg::result_t q_d [3];
  logic              pop;
  logic [1:0]        base;

  assign pop     = (count_q != 2'd0) && ready_i;
  assign base    = count_q - {1'b0, pop};
  assign valid_o = (count_q != 2'd0);
  assign head_o  = q_q[0];
  // Leave room for a two-result transfer
  assign room_o  = (count_q <= 2'd1);

  // Shift on pop, then append new results behind the survivors
  always_comb begin
    q_d[0] = pop ? q_q[1] : q_q[0];
    q_d[1] = pop ? q_q[2] : q_q[1];
    q_d[2] = q_q[2];
    for (int i = 0; i < 3; i++) begin
      if ((push_i.num != 2'd0) && (base == 2'(i))) begin
        q_d[i] = push_i.r0;
      end
      if ((push_i.num == 2'd2) && ((base + 2'd1) == 2'(i))) begin
        q_d[i] = push_i.r1;
      end
    end
    count_d = base + push_i.num;
  end

  // Hold entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  `ASSERT_IMPLIES(a_push_has_room, clk_i, rst_ni, push_i.num != 2'd0, room_o, "push without room")
  `ASSERT_IMPLIES(a_push_num_ok, clk_i, rst_ni, 1'b1, push_i.num != 2'd3, "push of three results")
  `ASSERT_NEXT(a_pop_drains, clk_i, rst_ni, pop && (push_i.num == 2'd0), count_q == $past(count_q) - 2'd1, "pop did not drain")

endmodule
`default_nettype wire

// ===== rtl/utf8_to_cp850_transcoder.sv =====
// Top level of the UTF-8 to CP850 transcoder: sequence decoder, lookup and result queue.
// Results: the input transfer that completes a result writes it into the registered result
// queue, from whose head the master side is driven.
// Throughput: one byte per cycle while the master side is ready; after a byte that gives two
// results the slave side pauses until the three-entry result queue drains to one entry.
// Reset: asynchronous, active low; clears the decoder phase, codepoint and queue count.
`default_nettype none
`include "assert_macros.svh"
module utf8_to_cp850_transcoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // string_last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]      m_axis_tuser,   // [0] substituted, [1] run_last
  output logic            m_axis_tlast    // string_done
);

  u8cp_pkg::phase_e  phase_q, phase_d;
  logic [15:0]       acc_q, acc_d;
  logic              s_fire;
  logic [7:0]        b;
  logic              last;
  logic [15:0]       cp;
  u8cp_pkg::lookup_t lk;
  u8cp_pkg::result_t map_res;
  u8cp_pkg::push_t   push;
  logic              room;
  u8cp_pkg::result_t head;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign b      = s_axis_tdata;
  assign last   = s_axis_tlast;
  assign s_axis_tready = room;

  // Map a finished codepoint
  assign cp = acc_q | {10'd0, b[5:0]};
  assign lk = u8cp_pkg::ucs_lookup(cp);
  always_comb begin
    map_res = '0;
    if (lk.hit) begin
      map_res.out_byte = {1'b1, lk.idx};
    end else if (cp < 16'h0080) begin
      map_res.out_byte = cp[7:0];
    end else begin
      map_res.out_byte    = u8cp_pkg::QMARK;
      map_res.substituted = 1'b1;
    end
  end

  // Decode the current byte against the held sequence
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    push    = '0;
    unique case (phase_q)
      u8cp_pkg::PH_IDLE: begin
        if (b < u8cp_pkg::ASCII_TOP) begin
          push.num         = 2'd1;
          push.r0.out_byte = b;
        end else if (((b & u8cp_pkg::LEAD2_MASK) == u8cp_pkg::LEAD2_CODE) && !last) begin
          acc_d   = {5'd0, b[4:0], 6'd0};
          phase_d = u8cp_pkg::PH_TWO;
        end else if (((b & u8cp_pkg::LEAD3_MASK) == u8cp_pkg::LEAD3_CODE) && !last) begin
          acc_d   = {b[3:0], 12'd0};
          phase_d = u8cp_pkg::PH_THREE_A;
        end else begin
          push.num            = 2'd1;
          push.r0.out_byte    = u8cp_pkg::QMARK;
          push.r0.substituted = 1'b1;
        end
      end
      u8cp_pkg::PH_THREE_A: begin
        if (last) begin
          // String cut short: drop the lead as '?', then the byte on its own
          push.num            = 2'd2;
          push.r0.out_byte    = u8cp_pkg::QMARK;
          push.r0.substituted = 1'b1;
          if (b < u8cp_pkg::ASCII_TOP) begin
            push.r1.out_byte = b;
          end else begin
            push.r1.out_byte    = u8cp_pkg::QMARK;
            push.r1.substituted = 1'b1;
          end
          phase_d = u8cp_pkg::PH_IDLE;
        end else begin
          acc_d   = acc_q | {4'd0, b[5:0], 6'd0};
          phase_d = u8cp_pkg::PH_THREE_B;
        end
      end
      u8cp_pkg::PH_TWO, u8cp_pkg::PH_THREE_B: begin
        push.num = 2'd1;
        push.r0  = map_res;
        phase_d  = u8cp_pkg::PH_IDLE;
      end
      default: begin
        phase_d = u8cp_pkg::PH_IDLE;
      end
    endcase
    if (phase_d == u8cp_pkg::PH_IDLE) begin
      acc_d = 16'd0;
    end
    // Mark the last result of this transfer
    if (push.num == 2'd2) begin
      push.r1.run_last    = 1'b1;
      push.r1.string_done = last;
    end else begin
      push.r0.run_last    = 1'b1;
      push.r0.string_done = last;
    end
    if (!s_fire) begin
      push.num = 2'd0;
    end
  end

  // Advance decoder state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= u8cp_pkg::PH_IDLE;
      acc_q   <= 16'd0;
    end else if (s_fire) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
    end
  end

  u8cp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tdata = head.out_byte;
  assign m_axis_tuser = {head.run_last, head.substituted};
  assign m_axis_tlast = head.string_done;

  `ASSERT_NEXT(a_last_idles, clk_i, rst_ni, s_fire && s_axis_tlast, phase_q == u8cp_pkg::PH_IDLE, "phase not idle after string end")
  `ASSERT_IMPLIES(a_last_gives_result, clk_i, rst_ni, s_fire && s_axis_tlast, push.num != 2'd0, "string end without result")
  `ASSERT_IMPLIES(a_done_is_run_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1], "string_done without run_last")
  `ASSERT_IMPLIES(a_idle_acc_clear, clk_i, rst_ni, phase_q == u8cp_pkg::PH_IDLE, acc_q == 16'd0, "codepoint not clear while idle")

endmodule
`default_nettype wire
